FILE: src/stoi_pkg.sv
// Shared types and constants for the string to int64 parser.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package stoi_pkg;

  // Parse phases of the controller.
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SPACE  = 3'd1;
  localparam logic [2:0] PH_SIGNED = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;

  // Digit status codes.
  localparam logic [1:0] DS_NONE = 2'd0;
  localparam logic [1:0] DS_SOME = 2'd1;
  localparam logic [1:0] DS_OVER = 2'd2;

  // Saturation limits (magnitudes).
  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  // Width of the end offset field on the result channel.
  localparam int unsigned END_OFF_W = 16;

  // Character codes.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 acc_zero;    // treat the accumulator as zero (new string)
    logic                 acc_en;      // write the accumulator this cycle
    logic                 acc_load;    // take accumulator * base + digit
    logic [5:0]           base;        // base in effect for the digit check
    logic                 negative;    // sign of the string
    logic                 res_load;    // capture a result
    logic                 res_any;     // at least one digit was taken
    logic                 res_over;    // value saturated
    logic [END_OFF_W-1:0] res_offset;  // end offset of the result
  } stoi_cmd_t;

  // Character class and arithmetic status from the datapath.
  typedef struct packed {
    logic is_space;
    logic is_minus;
    logic is_plus;
    logic is_zero;
    logic is_x;
    logic digit_ok;  // a digit below the active base
    logic fits;      // accumulator * base + digit stays within the limit
  } stoi_stat_t;

endpackage

`default_nettype wire

FILE: src/stoi_in_if.sv
// Input channel of the parser: one character per request.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface stoi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       start_req;
  logic [5:0] radix;

  modport source (output valid, output ch, output start_req, output radix, input ready);
  modport sink   (input valid, input ch, input start_req, input radix, output ready);
endinterface

`default_nettype wire

FILE: src/stoi_out_if.sv
// Result channel of the parser: one request per parsed string.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface stoi_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic [15:0]        end_offset;
  logic               any_digits;
  logic               out_of_range;

  modport source (output valid, output value, output end_offset, output any_digits,
                  output out_of_range, input ready);
  modport sink   (input valid, input value, input end_offset, input any_digits,
                  input out_of_range, output ready);
endinterface

`default_nettype wire

FILE: src/stoi_dp.sv
// Datapath of the parser: character decode, accumulator with overflow check,
// and the result register. Depends on stoi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stoi_dp
  import stoi_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [7:0]         ch_i,
  input  wire stoi_cmd_t          cmd_i,
  output      stoi_stat_t         stat_o,
  output      logic signed [63:0] value_o,
  output      logic [15:0]        end_offset_o,
  output      logic               any_digits_o,
  output      logic               out_of_range_o
);

  logic [63:0] acc_q;
  logic [63:0] acc_cur;
  logic [5:0]  digit;
  logic        is_alnum;
  logic [69:0] prod;
  logic [69:0] sum;
  logic [69:0] limit;
  logic [63:0] value_d;

  logic [63:0]          value_q;
  logic [END_OFF_W-1:0] offset_q;
  logic                 any_q;
  logic                 over_q;

  // Character classification and digit value.
  always_comb begin
    digit    = 6'd0;
    is_alnum = 1'b0;
    if (ch_i >= CH_ZERO && ch_i <= CH_NINE) begin
      digit    = 6'(ch_i - CH_ZERO);
      is_alnum = 1'b1;
    end else if (ch_i >= CH_UA && ch_i <= CH_UZ) begin
      digit    = 6'(ch_i - CH_UA + 8'd10);
      is_alnum = 1'b1;
    end else if (ch_i >= CH_LA && ch_i <= CH_LZ) begin
      digit    = 6'(ch_i - CH_LA + 8'd10);
      is_alnum = 1'b1;
    end
  end

  // Multiply-accumulate and the limit compare. A new digit fits exactly when
  // acc * base + digit does not exceed the limit for the sign.
  assign acc_cur = cmd_i.acc_zero ? 64'd0 : acc_q;
  assign prod    = 70'(acc_cur) * 70'(cmd_i.base);
  assign sum     = prod + 70'(digit);
  assign limit   = cmd_i.negative ? 70'(NEG_LIMIT) : 70'(POS_LIMIT);

  always_comb begin
    stat_o.is_space = (ch_i == CH_SPACE) || (ch_i >= CH_TAB && ch_i <= CH_CR);
    stat_o.is_minus = (ch_i == CH_MINUS);
    stat_o.is_plus  = (ch_i == CH_PLUS);
    stat_o.is_zero  = (ch_i == CH_ZERO);
    stat_o.is_x     = (ch_i == CH_UX) || (ch_i == CH_LX);
    stat_o.digit_ok = is_alnum && (digit < cmd_i.base);
    stat_o.fits     = (sum <= limit);
  end

  // Accumulator register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 64'd0;
    end else if (cmd_i.acc_en) begin
      acc_q <= cmd_i.acc_load ? sum[63:0] : acc_cur;
    end
  end

  // Final value: saturated limit, or the magnitude with its sign applied.
  always_comb begin
    if (cmd_i.res_over) begin
      value_d = limit[63:0];
    end else if (cmd_i.negative) begin
      value_d = 64'd0 - acc_cur;
    end else begin
      value_d = acc_cur;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      value_q  <= value_d;
      offset_q <= cmd_i.res_offset;
      any_q    <= cmd_i.res_any;
      over_q   <= cmd_i.res_over;
    end
  end

  assign value_o        = value_q;
  assign end_offset_o   = offset_q;
  assign any_digits_o   = any_q;
  assign out_of_range_o = over_q;

endmodule

`default_nettype wire

FILE: src/stoi_ctrl.sv
// Controller of the parser: parse phase, sign, digit status, base, offset
// and the result handshake. Depends on stoi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stoi_ctrl
  import stoi_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic       start_req_i,
  input  wire logic [5:0] radix_i,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  input  wire stoi_stat_t stat_i,
  output      stoi_cmd_t  cmd_o
);

  logic [2:0]             phase_q, phase_d;
  logic                   neg_q, neg_d;
  logic [1:0]             ds_q, ds_d;
  logic [5:0]             base_q, base_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic                   out_valid_q;

  logic [2:0]             cur_phase;
  logic                   cur_neg;
  logic [1:0]             cur_ds;
  logic [5:0]             cur_base;
  logic [OFFSET_BITS-1:0] cur_off;
  logic [5:0]             eff_base;
  logic [31:0]            off_ext;
  logic                   fire;
  logic                   first;
  logic                   take;
  logic                   load;
  logic                   done;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  // A start request opens a new context: whitespace phase, positive sign, no digits, zero offset, base from radix.
  assign cur_phase = start_req_i ? PH_SPACE : phase_q;
  assign cur_neg   = start_req_i ? 1'b0 : neg_q;
  assign cur_ds    = start_req_i ? DS_NONE : ds_q;
  assign cur_base  = start_req_i ? radix_i : base_q;
  assign cur_off   = start_req_i ? '0 : off_q;

  // Base used for the digit check in this step; base 0 defaults by phase.
  always_comb begin
    if (cur_phase == PH_DIGITS) begin
      eff_base = cur_base;
    end else if (cur_base != 6'd0) begin
      eff_base = cur_base;
    end else if (cur_phase == PH_ZERO) begin
      eff_base = 6'd8;
    end else begin
      eff_base = 6'd10;
    end
  end

  // Phase transitions for one character.
  always_comb begin
    phase_d = cur_phase;
    neg_d   = cur_neg;
    ds_d    = cur_ds;
    base_d  = cur_base;
    first   = 1'b0;
    take    = 1'b0;
    load    = 1'b0;
    done    = 1'b0;

    unique case (cur_phase)
      PH_SPACE: begin
        if (stat_i.is_space) begin
          phase_d = PH_SPACE;
        end else if (stat_i.is_minus) begin
          neg_d   = 1'b1;
          phase_d = PH_SIGNED;
        end else if (stat_i.is_plus) begin
          phase_d = PH_SIGNED;
        end else begin
          first = 1'b1;
        end
      end
      PH_SIGNED: begin
        first = 1'b1;
      end
      PH_ZERO: begin
        phase_d = PH_DIGITS;
        if (stat_i.is_x) begin
          base_d = 6'd16;
        end else begin
          // The leading zero counts as a digit.
          base_d = eff_base;
          ds_d   = DS_SOME;
          take   = 1'b1;
        end
      end
      PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    // First character after whitespace and sign: a zero may open a prefix.
    if (first) begin
      if ((cur_base == 6'd0 || cur_base == 6'd16) && stat_i.is_zero) begin
        phase_d = PH_ZERO;
      end else begin
        base_d  = eff_base;
        phase_d = PH_DIGITS;
        take    = 1'b1;
      end
    end

    // Digit step: terminate, ignore after overflow, saturate or accumulate.
    if (take) begin
      if (!stat_i.digit_ok) begin
        done = 1'b1;
      end else if (ds_d == DS_OVER) begin
        ds_d = DS_OVER;
      end else if (!stat_i.fits) begin
        ds_d = DS_OVER;
      end else begin
        ds_d = DS_SOME;
        load = 1'b1;
      end
    end

    if (done) begin
      phase_d = PH_IDLE;
    end
  end

  // Offset counts every consumed character but the terminating one, and saturates.
  always_comb begin
    off_d = cur_off;
    if (!done && cur_phase != PH_IDLE && cur_off != {OFFSET_BITS{1'b1}}) begin
      off_d = cur_off + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
    end
  end

  assign off_ext = 32'(cur_off);

  // Commands to the datapath.
  always_comb begin
    cmd_o.acc_zero   = start_req_i;
    cmd_o.acc_en     = fire;
    cmd_o.acc_load   = load;
    cmd_o.base       = eff_base;
    cmd_o.negative   = cur_neg;
    cmd_o.res_load   = fire && done;
    cmd_o.res_any    = (ds_d != DS_NONE);
    cmd_o.res_over   = (ds_d == DS_OVER);
    cmd_o.res_offset = (ds_d != DS_NONE) ? off_ext[END_OFF_W-1:0] : '0;
  end

  // Parse context registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      neg_q   <= 1'b0;
      ds_q    <= DS_NONE;
      base_q  <= 6'd0;
      off_q   <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      ds_q    <= ds_d;
      base_q  <= base_d;
      off_q   <= off_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: src/string_to_int64_parser_top.sv
// String to signed 64-bit integer parser, top level.
//
// The input channel carries one character per request. A request with
// start_req set opens a new string and samples radix (0 auto-detects base
// 8, 10 or 16). Leading whitespace, one sign and an optional 0x prefix are
// read, then digits below the base are accumulated with saturation to the
// signed 64-bit limits. The first character that is not such a digit ends
// the string and produces one request on the result channel: value, end
// offset (0 when no digit was taken), any_digits and out_of_range.
// Characters with start_req clear outside a string are dropped.
//
// Throughput is one character per cycle; each character passes through the
// multiply-accumulate and limit compare in the cycle it is accepted. The
// result is registered and appears in the cycle after its terminating
// character is accepted. While a result waits and the receiver holds
// ready low, input ready drops; otherwise input is taken every cycle. Reset
// idles the parser and clears result valid but not the result register.
// Depends on stoi_pkg, stoi_in_if, stoi_out_if, stoi_ctrl and stoi_dp.
`timescale 1ns / 1ps
`default_nettype none

module string_to_int64_parser_top
  import stoi_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  stoi_in_if.sink    in_i,
  stoi_out_if.source out_o
);

  stoi_cmd_t  cmd;
  stoi_stat_t stat;

  // Parse sequencing and handshakes.
  stoi_ctrl #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .start_req_i (in_i.start_req),
    .radix_i     (in_i.radix),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Decode, accumulate and hold the result.
  stoi_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ch_i           (in_i.ch),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .value_o        (out_o.value),
    .end_offset_o   (out_o.end_offset),
    .any_digits_o   (out_o.any_digits),
    .out_of_range_o (out_o.out_of_range)
  );

endmodule

`default_nettype wire
